// File: rtl/core/pfdf_pkg.sv
// ----------------------------------------------------------------------------
// pfdf_pkg
// Shared types and constants for the palette frame buffer with dirty flush.
// ----------------------------------------------------------------------------
`default_nettype none

package pfdf_pkg;

  localparam int FrameWidthDef  = 128;
  localparam int FrameHeightDef = 128;
  localparam int IndexBitsDef   = 4;

  localparam int OutColorBits = 16;
  localparam int CmdBits      = 3;
  localparam int PosBits      = 7;
  localparam int PortIdxBits  = 4;
  localparam int CfgAddrBits  = 3;
  localparam int CfgDataBits  = 16;
  localparam int SizeBits     = 8;
  localparam int MarkBits     = 2;

  localparam logic [MarkBits-1:0] MarkNone  = 2'd0;
  localparam logic [MarkBits-1:0] MarkOnce  = 2'd1;
  localparam logic [MarkBits-1:0] MarkDirty = 2'd2;

  typedef enum logic [CmdBits-1:0] {
    CMD_SET_PIXEL   = 3'd0,
    CMD_GET_PIXEL   = 3'd1,
    CMD_CLEAR       = 3'd2,
    CMD_FLUSH_STEP  = 3'd3,
    CMD_SET_PALETTE = 3'd4
  } cmd_e;

  typedef enum logic [CfgAddrBits-1:0] {
    REG_USED_WIDTH        = 3'd0,
    REG_USED_HEIGHT       = 3'd1,
    REG_SCALE_HORIZONTAL  = 3'd2,
    REG_SCALE_VERTICAL    = 3'd3,
    REG_OFFSET_HORIZONTAL = 3'd4,
    REG_OFFSET_VERTICAL   = 3'd5,
    REG_CLEAR_INDEX       = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SWEEP
  } ctrl_state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic sweep;
    logic sweep_init;
    logic finish;
  } dp_ctrl_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pfdf_ctrl.sv
// ----------------------------------------------------------------------------
// pfdf_ctrl
// Command sequencer: reset clearing pass, read/execute steps and clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdf_ctrl
  import pfdf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [CmdBits-1:0] cmd_i,
  input  wire dp_status_t         status_i,
  output dp_ctrl_t                ctrl_o,
  output logic                    busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = (cmd_e'(cmd_i) == CMD_CLEAR) ? ST_SWEEP : ST_READ;
        end
      end
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_INIT;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        ctrl_o.sweep      = 1'b1;
        ctrl_o.sweep_init = 1'b1;
      end
      ST_IDLE: begin
        busy_o       = 1'b0;
        ctrl_o.latch = start_i;
      end
      ST_READ: ;
      ST_EXEC: ctrl_o.exec = 1'b1;
      ST_SWEEP: begin
        ctrl_o.sweep  = 1'b1;
        ctrl_o.finish = status_i.sweep_last;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_exec_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> $past(state_q) == ST_READ)
    else $error("execute step without read step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch |-> state_q == ST_IDLE && !ctrl_o.sweep)
    else $error("command latched while busy");
  a_finish_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |=> state_q == ST_IDLE)
    else $error("clear sweep did not return to idle");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pfdf_datapath.sv
// ----------------------------------------------------------------------------
// pfdf_datapath
// Pixel and mark memories, palette, settings, scan position and results.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdf_datapath
  import pfdf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FrameWidthDef,
  parameter int FRAME_HEIGHT = FrameHeightDef,
  parameter int INDEX_BITS   = IndexBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrBits-1:0]  cfg_addr_i,
  input  wire logic [CfgDataBits-1:0]  cfg_wdata_i,
  input  wire logic [CmdBits-1:0]      cmd_i,
  input  wire logic [PosBits-1:0]      column_i,
  input  wire logic [PosBits-1:0]      row_i,
  input  wire logic [PortIdxBits-1:0]  color_index_i,
  input  wire logic [OutColorBits-1:0] palette_color_i,
  input  wire dp_ctrl_t                ctrl_i,
  output dp_status_t                   status_o,
  output logic                         done_o,
  output logic [PortIdxBits-1:0]       read_index_o,
  output logic                         write_rect_o,
  output logic [OutColorBits-1:0]      rect_x_o,
  output logic [OutColorBits-1:0]      rect_y_o,
  output logic [OutColorBits-1:0]      rect_color_o,
  output logic                         scan_last_o
);

  localparam int Pixels  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW   = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int Colors  = 1 << INDEX_BITS;
  localparam int IdxW    = (INDEX_BITS > PortIdxBits) ? INDEX_BITS : PortIdxBits;
  localparam int MaxW    = (FRAME_WIDTH < 255) ? FRAME_WIDTH : 255;
  localparam int MaxH    = (FRAME_HEIGHT < 255) ? FRAME_HEIGHT : 255;
  localparam int ColW    = (MaxW > 1) ? $clog2(MaxW) : 1;
  localparam int RowW    = (MaxH > 1) ? $clog2(MaxH) : 1;
  localparam logic [10:0] FwL = 11'(FRAME_WIDTH);
  localparam logic [10:0] FhL = 11'(FRAME_HEIGHT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Pixels - 1);

  // settings
  logic [SizeBits-1:0]     used_w_q, used_h_q, scale_h_q, scale_v_q;
  logic [OutColorBits-1:0] off_h_q, off_v_q;
  logic [PortIdxBits-1:0]  clear_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_w_q    <= SizeBits'(MaxW);
      used_h_q    <= SizeBits'(MaxH);
      scale_h_q   <= SizeBits'(1);
      scale_v_q   <= SizeBits'(1);
      off_h_q     <= '0;
      off_v_q     <= '0;
      clear_idx_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_USED_WIDTH:        used_w_q    <= cfg_wdata_i[SizeBits-1:0];
        REG_USED_HEIGHT:       used_h_q    <= cfg_wdata_i[SizeBits-1:0];
        REG_SCALE_HORIZONTAL:  scale_h_q   <= cfg_wdata_i[SizeBits-1:0];
        REG_SCALE_VERTICAL:    scale_v_q   <= cfg_wdata_i[SizeBits-1:0];
        REG_OFFSET_HORIZONTAL: off_h_q     <= cfg_wdata_i;
        REG_OFFSET_VERTICAL:   off_v_q     <= cfg_wdata_i;
        REG_CLEAR_INDEX:       clear_idx_q <= cfg_wdata_i[PortIdxBits-1:0];
        default: ;
      endcase
    end
  end

  logic [SizeBits-1:0] eff_w, eff_h;
  logic                empty;

  assign eff_w = ({3'b000, used_w_q} > FwL) ? FwL[SizeBits-1:0] : used_w_q;
  assign eff_h = ({3'b000, used_h_q} > FhL) ? FhL[SizeBits-1:0] : used_h_q;
  assign empty = (eff_w == '0) || (eff_h == '0);

  // latched command
  cmd_e                    cmd_q;
  logic [PosBits-1:0]      col_q, row_q;
  logic [INDEX_BITS-1:0]   cidx_q;
  logic [OutColorBits-1:0] pcol_q;
  logic [IdxW-1:0]         cidx_wide, clr_wide;

  assign cidx_wide = IdxW'(color_index_i);
  assign clr_wide  = IdxW'(clear_idx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= cmd_e'(cmd_i);
      col_q  <= column_i;
      row_q  <= row_i;
      cidx_q <= cidx_wide[INDEX_BITS-1:0];
      pcol_q <= palette_color_i;
    end
  end

  // scan position
  logic [ColW-1:0]  scan_col_q, scan_col_d, pos_col, pos_col_q;
  logic [RowW-1:0]  scan_row_q, scan_row_d, pos_row, pos_row_q;
  logic [AddrW-1:0] rd_addr, addr_q;
  logic             restart;

  assign restart = (SizeBits'(scan_col_q) >= eff_w) || (SizeBits'(scan_row_q) >= eff_h);
  assign pos_col = restart ? '0 : scan_col_q;
  assign pos_row = restart ? '0 : scan_row_q;

  always_comb begin
    if (cmd_q == CMD_FLUSH_STEP) begin
      rd_addr = AddrW'(32'(pos_row) * 32'(FRAME_WIDTH) + 32'(pos_col));
    end else begin
      rd_addr = AddrW'(32'(row_q) * 32'(FRAME_WIDTH) + 32'(col_q));
    end
  end

  always_ff @(posedge clk_i) begin
    pos_col_q <= pos_col;
    pos_row_q <= pos_row;
    addr_q    <= rd_addr;
  end

  // memories
  logic [INDEX_BITS-1:0] pix_mem [Pixels];
  logic [MarkBits-1:0]   mark_mem [Pixels];
  logic [INDEX_BITS-1:0] pix_rd_q, pix_wdata;
  logic [MarkBits-1:0]   mark_rd_q, mark_wdata;
  logic [AddrW-1:0]      waddr, sweep_cnt_q;
  logic                  pix_we, mark_we;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[waddr] <= pix_wdata;
    end
    pix_rd_q <= pix_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[waddr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[rd_addr];
  end

  // clear sweep
  logic first_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q  <= '0;
      first_done_q <= 1'b0;
    end else begin
      if (ctrl_i.sweep) begin
        sweep_cnt_q <= (sweep_cnt_q == LastAddr) ? '0 : sweep_cnt_q + 1'b1;
      end
      if (ctrl_i.finish) begin
        first_done_q <= 1'b1;
      end
    end
  end

  assign status_o.sweep_last = (sweep_cnt_q == LastAddr);

  // palette
  logic [OutColorBits-1:0] palette_q [Colors];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Colors; i++) begin
        palette_q[i] <= '0;
      end
    end else if (ctrl_i.exec && cmd_q == CMD_SET_PALETTE) begin
      palette_q[cidx_q] <= {pcol_q[7:0], pcol_q[15:8]};
    end
  end

  // execute step
  logic                    in_area, last_col, last_row;
  logic [IdxW-1:0]         pix_wide;
  logic [PortIdxBits-1:0]  res_index;
  logic                    res_rect, res_last;
  logic [OutColorBits-1:0] res_x, res_y, res_color;

  assign in_area  = (SizeBits'(col_q) < eff_w) && (SizeBits'(row_q) < eff_h);
  assign pix_wide = IdxW'(pix_rd_q);
  assign last_col = ({1'b0, SizeBits'(pos_col_q)} + 9'd1) >= {1'b0, eff_w};
  assign last_row = ({1'b0, SizeBits'(pos_row_q)} + 9'd1) >= {1'b0, eff_h};

  always_comb begin
    res_index  = '0;
    res_rect   = 1'b0;
    res_last   = 1'b0;
    res_x      = '0;
    res_y      = '0;
    res_color  = '0;
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    pix_we     = 1'b0;
    mark_we    = 1'b0;
    waddr      = addr_q;
    pix_wdata  = cidx_q;
    mark_wdata = MarkNone;
    if (ctrl_i.sweep) begin
      waddr      = sweep_cnt_q;
      pix_we     = 1'b1;
      pix_wdata  = ctrl_i.sweep_init ? '0 : clr_wide[INDEX_BITS-1:0];
      mark_we    = ctrl_i.sweep_init || !first_done_q;
      mark_wdata = ctrl_i.sweep_init ? MarkNone : MarkOnce;
    end else if (ctrl_i.exec) begin
      case (cmd_q)
        CMD_SET_PIXEL: begin
          pix_we     = in_area;
          mark_we    = in_area;
          mark_wdata = mark_rd_q | MarkDirty;
        end
        CMD_GET_PIXEL: begin
          if (in_area) begin
            res_index = pix_wide[PortIdxBits-1:0];
          end
        end
        CMD_FLUSH_STEP: begin
          if (empty) begin
            scan_col_d = '0;
            scan_row_d = '0;
            res_last   = 1'b1;
          end else begin
            if (mark_rd_q != MarkNone) begin
              res_rect   = 1'b1;
              res_x      = off_h_q + 16'({8'd0, scale_h_q} * 16'(pos_col_q));
              res_y      = off_v_q + 16'({8'd0, scale_v_q} * 16'(pos_row_q));
              res_color  = palette_q[pix_rd_q];
              mark_we    = 1'b1;
              mark_wdata = mark_rd_q[1] ? MarkOnce : MarkNone;
            end
            if (!last_col) begin
              scan_col_d = pos_col_q + 1'b1;
              scan_row_d = pos_row_q;
            end else begin
              scan_col_d = '0;
              if (!last_row) begin
                scan_row_d = pos_row_q + 1'b1;
              end else begin
                scan_row_d = '0;
                res_last   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q <= '0;
      scan_row_q <= '0;
      done_q     <= 1'b0;
    end else begin
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      done_q     <= ctrl_i.exec || ctrl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec || ctrl_i.finish) begin
      read_index_o <= res_index;
      write_rect_o <= res_rect;
      rect_x_o     <= res_x;
      rect_y_o     <= res_y;
      rect_color_o <= res_color;
      scan_last_o  <= res_last;
    end
  end

  assign done_o = done_q;

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");
  a_sweep_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec |-> sweep_cnt_q == '0)
    else $error("sweep counter not parked outside a sweep");
  a_first_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_done_q |=> first_done_q)
    else $error("first clear flag dropped");
  a_no_write_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.sweep |-> !ctrl_i.exec && !ctrl_i.latch)
    else $error("sweep overlaps a command");
`endif

endmodule

`default_nettype wire

// File: rtl/core/palette_framebuffer_dirty_flush_top.sv
// ----------------------------------------------------------------------------
// palette_framebuffer_dirty_flush_top
// Indexed-color frame store with per-pixel redraw marks and stepped flush.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  command  | start, busy             | cmd_i, column_i, row_i, color_index_i,
//           |                         | palette_color_i
//  result   | done_o (one-cycle)      | read_index_o, write_rect_o, rect_x_o,
//           |                         | rect_y_o, rect_color_o, scan_last_o
//  config   | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
//  Commands other than clear pass through accept, memory read and execute;
//  done_o pulses in the cycle after execute, when the next command can be taken.
//  Clear walks all FRAME_WIDTH*FRAME_HEIGHT entries of the pixel memory one
//  entry a cycle, then pulses done_o. After reset a clearing pass over all
//  entries holds busy high.
//  Results cannot be stalled; each is valid only while done_o is high.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_framebuffer_dirty_flush_top
  import pfdf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FrameWidthDef,
  parameter int FRAME_HEIGHT = FrameHeightDef,
  parameter int INDEX_BITS   = IndexBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CmdBits-1:0]      cmd_i,
  input  wire logic [PosBits-1:0]      column_i,
  input  wire logic [PosBits-1:0]      row_i,
  input  wire logic [PortIdxBits-1:0]  color_index_i,
  input  wire logic [OutColorBits-1:0] palette_color_i,
  output logic                         done_o,
  output logic [PortIdxBits-1:0]       read_index_o,
  output logic                         write_rect_o,
  output logic [OutColorBits-1:0]      rect_x_o,
  output logic [OutColorBits-1:0]      rect_y_o,
  output logic [OutColorBits-1:0]      rect_color_o,
  output logic                         scan_last_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrBits-1:0]  cfg_addr_i,
  input  wire logic [CfgDataBits-1:0]  cfg_wdata_i
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  pfdf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  pfdf_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .INDEX_BITS   (INDEX_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .color_index_i   (color_index_i),
    .palette_color_i (palette_color_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .done_o          (done_o),
    .read_index_o    (read_index_o),
    .write_rect_o    (write_rect_o),
    .rect_x_o        (rect_x_o),
    .rect_y_o        (rect_y_o),
    .rect_color_o    (rect_color_o),
    .scan_last_o     (scan_last_o)
  );

endmodule

`default_nettype wire
